>>> hw/rtl/soc_pkg.sv
// Shared types and constants for the shuffled order cursor block.
// No dependencies; compiled first.
package soc_pkg;

  // Default number of surface ids in the order list
  localparam int NUM_IDS_DEFAULT = 6;

  // Field widths of the item channels
  localparam int RAND_W = 31;
  localparam int OUT_W  = 3;

  // Highest id that has an opposite face (pairs 0-1, 2-3, 4-5)
  localparam int MAX_FACE_ID = 5;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_CUBE_MODE = 1'b0;  // register index (paddr[2])

  // Item commands
  localparam logic CMD_DRAW    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Result of one item
  typedef struct packed {
    logic [OUT_W-1:0] current_id;
    logic [OUT_W-1:0] cursor;
    logic             shuffle_complete;
  } soc_result_t;

endpackage

>>> hw/rtl/soc_if.sv
// Valid/ready channel interfaces for the request and result items.
// Depends on soc_pkg.
interface soc_req_if
  import soc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [RAND_W-1:0] random_word;

  modport source (output valid, output cmd, output random_word, input ready);
  modport sink   (input valid, input cmd, input random_word, output ready);
endinterface

interface soc_rsp_if
  import soc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] current_id;
  logic [OUT_W-1:0] cursor;
  logic             shuffle_complete;

  modport source (output valid, output current_id, output cursor, output shuffle_complete,
                  input ready);
  modport sink   (input valid, input current_id, input cursor, input shuffle_complete,
                  output ready);
endinterface

>>> hw/rtl/soc_apb_regs.sv
// APB-style configuration register: cube_mode.
// Depends on soc_pkg.
module soc_apb_regs
  import soc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic               cube_mode
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register write; addresses beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cube_mode <= 1'b0;
    end else if (wr_en && (paddr[2] == REG_CUBE_MODE)) begin
      cube_mode <= pwdata[0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CUBE_MODE) begin
      prdata[0] = cube_mode;
    end
  end

endmodule

>>> hw/rtl/soc_step.sv
// Single-pass item logic: one Fisher-Yates swap or one cursor advance.
// Depends on soc_pkg.
module soc_step
  import soc_pkg::*;
#(
  parameter int NUM_IDS = NUM_IDS_DEFAULT,
  parameter int ID_W    = $clog2(NUM_IDS)
) (
  input  logic                          cmd,
  input  logic [RAND_W-1:0]             random_word,
  input  logic                          cube_mode,
  input  logic [NUM_IDS-1:0][ID_W-1:0]  order_list,
  input  logic [ID_W-1:0]               draws_left,
  input  logic [ID_W-1:0]               cursor_pos,
  output logic [NUM_IDS-1:0][ID_W-1:0]  order_next,
  output logic [ID_W-1:0]               draws_next,
  output logic [ID_W-1:0]               cursor_next,
  output soc_result_t                   result
);

  localparam int PROD_W = RAND_W + ID_W + 1;

  logic                         restart;
  logic [NUM_IDS-1:0][ID_W-1:0] base_list;
  logic [NUM_IDS-1:0][ID_W-1:0] swapped;
  logic [ID_W-1:0]              k;
  logic [ID_W:0]                k_plus;
  logic [PROD_W-1:0]            prod;
  logic [ID_W-1:0]              j;
  logic [ID_W-1:0]              last_id;
  logic [ID_W-1:0]              next_id;
  logic [ID_W-1:0]              cur1;
  logic                         skip;

  function automatic logic [ID_W-1:0] wrap_next(input logic [ID_W-1:0] p);
    if (p == ID_W'(NUM_IDS - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  // A draw with no shuffle pending starts over from the identity order
  assign restart = (cmd == CMD_DRAW) && (draws_left == '0);

  always_comb begin
    for (int i = 0; i < NUM_IDS; i++) begin
      base_list[i] = restart ? ID_W'(i) : order_list[i];
    end
  end

  // Swap index j = (r * (k+1)) >> 31, always <= k
  assign k      = restart ? ID_W'(NUM_IDS - 1) : draws_left;
  assign k_plus = (ID_W + 1)'(k) + 1'b1;
  assign prod   = PROD_W'(random_word) * PROD_W'(k_plus);
  assign j      = prod[RAND_W +: ID_W];

  always_comb begin
    for (int i = 0; i < NUM_IDS; i++) begin
      if (ID_W'(i) == k) begin
        swapped[i] = base_list[j];
      end else if (ID_W'(i) == j) begin
        swapped[i] = base_list[k];
      end else begin
        swapped[i] = base_list[i];
      end
    end
  end

  // Advance: step once, and once more past an opposite face in cube mode
  assign last_id = order_list[cursor_pos];
  assign cur1    = wrap_next(cursor_pos);
  assign next_id = order_list[cur1];
  assign skip    = cube_mode && (32'(last_id) <= 32'(MAX_FACE_ID)) &&
                   (next_id == (last_id ^ ID_W'(1)));

  // Next state and result
  always_comb begin
    if (cmd == CMD_DRAW) begin
      order_next  = swapped;
      draws_next  = k - 1'b1;
      cursor_next = restart ? '0 : cursor_pos;
    end else begin
      order_next  = order_list;
      draws_next  = draws_left;
      cursor_next = skip ? wrap_next(cur1) : cur1;
    end
    result.current_id       = OUT_W'(order_next[cursor_next]);
    result.cursor           = OUT_W'(cursor_next);
    result.shuffle_complete = (draws_next == '0);
  end

endmodule

>>> hw/rtl/shuffled_order_cursor_core.sv
// Top level of the shuffled order cursor: input register, step logic, result register.
// Depends on soc_pkg, soc_if, soc_apb_regs and soc_step.
//
//   channel  kind          fields
//   req      valid/ready   cmd, random_word
//   rsp      valid/ready   current_id, cursor, shuffle_complete
//   apb      APB write/rd  cube_mode at byte address 0
//
// One item per cycle sustained while rsp.ready stays high; rsp.valid rises once an accepted item
// has passed the input register, then the swap/advance logic into the result register.
// Synchronous reset loads the identity order, clears cursor, draws_left and cube_mode.
// A stalled result holds the result register and the input register; req.ready
// drops only when both are full and rsp.ready is low.
module shuffled_order_cursor_core
  import soc_pkg::*;
#(
  parameter int NUM_IDS = NUM_IDS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  soc_req_if.sink            req,
  soc_rsp_if.source          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int ID_W = $clog2(NUM_IDS);

  logic                         cube_mode;
  logic                         in_valid;
  logic                         in_cmd;
  logic [RAND_W-1:0]            in_rand;
  logic                         out_valid;
  soc_result_t                  out_res;
  logic                         step_fire;
  logic [NUM_IDS-1:0][ID_W-1:0] order_list;
  logic [NUM_IDS-1:0][ID_W-1:0] order_next;
  logic [ID_W-1:0]              draws_left;
  logic [ID_W-1:0]              draws_next;
  logic [ID_W-1:0]              cursor_pos;
  logic [ID_W-1:0]              cursor_next;
  soc_result_t                  res_next;

  soc_apb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cube_mode (cube_mode)
  );

  // Handshake: the step runs when the result register is free or being drained
  assign step_fire = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || step_fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_cmd  <= req.cmd;
      in_rand <= req.random_word;
    end
  end

  soc_step #(
    .NUM_IDS (NUM_IDS),
    .ID_W    (ID_W)
  ) u_step (
    .cmd         (in_cmd),
    .random_word (in_rand),
    .cube_mode   (cube_mode),
    .order_list  (order_list),
    .draws_left  (draws_left),
    .cursor_pos  (cursor_pos),
    .order_next  (order_next),
    .draws_next  (draws_next),
    .cursor_next (cursor_next),
    .result      (res_next)
  );

  // Shuffle state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_IDS; i++) begin
        order_list[i] <= ID_W'(i);
      end
      draws_left <= '0;
      cursor_pos <= '0;
    end else if (step_fire) begin
      order_list <= order_next;
      draws_left <= draws_next;
      cursor_pos <= cursor_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_res <= res_next;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.current_id       = out_res.current_id;
  assign rsp.cursor           = out_res.cursor;
  assign rsp.shuffle_complete = out_res.shuffle_complete;

`ifndef NO_ASSERTIONS
  // Cursor never leaves the list
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    32'(cursor_pos) < NUM_IDS)
    else $error("cursor out of range");

  // A pending result reflects the current draw count
  a_complete_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.shuffle_complete == (draws_left == '0)))
    else $error("shuffle_complete disagrees with draws_left");

  // A draw inside a shuffle counts down by one
  a_draw_count: assert property (@(posedge clk) disable iff (rst)
    (step_fire && (in_cmd == CMD_DRAW) && (draws_left != '0)) |=>
      (draws_left == $past(draws_left) - 1'b1))
    else $error("draw did not count down");

  // An advance leaves the order untouched
  a_advance_keeps_order: assert property (@(posedge clk) disable iff (rst)
    (step_fire && (in_cmd == CMD_ADVANCE)) |=> $stable(order_list))
    else $error("advance changed the order list");
`endif

endmodule

>>> tb/tb_shuffled_order_cursor_core.sv
// Self-checking testbench for shuffled_order_cursor_core: directed and random items
// against an in-bench model of the shuffle and cursor. Needs soc_pkg, soc_if and the RTL.
module tb_shuffled_order_cursor_core;
  import soc_pkg::*;

  localparam int NUM_IDS = NUM_IDS_DEFAULT;
  localparam logic [PADDR_W-1:0] ADDR_CUBE_MODE = {REG_CUBE_MODE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED  = 3'd4;
  localparam logic [RAND_W-1:0]  WORD_MAX       = {RAND_W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  soc_req_if req_if ();
  soc_rsp_if rsp_if ();

  shuffled_order_cursor_core #(
    .NUM_IDS (NUM_IDS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Model state: order list, pending draws, cursor and cube mode
  logic [OUT_W-1:0] order_model [NUM_IDS];
  logic [OUT_W-1:0] draws_pending;
  logic [OUT_W-1:0] cursor_model;
  logic             cube_model;

  soc_result_t expected_results[$];
  int          mismatch_cnt = 0;
  int          burst_left   = 0;

  // One shuffle step or cursor move; returns the result the block should give
  function automatic soc_result_t predict_surface(input logic c, input logic [RAND_W-1:0] r);
    int unsigned      k;
    int unsigned      j;
    int unsigned      pos;
    int unsigned      last;
    logic [63:0]      prod;
    logic [OUT_W-1:0] t;
    soc_result_t      res;
    pos = cursor_model;
    if (c == CMD_DRAW) begin
      // a draw after a finished shuffle restarts from identity
      if (draws_pending == 0) begin
        for (int i = 0; i < NUM_IDS; i++) order_model[i] = OUT_W'(i);
        cursor_model  = '0;
        pos           = 0;
        draws_pending = OUT_W'(NUM_IDS - 1);
      end
      k    = draws_pending;
      prod = 64'(r) * 64'(k + 1);
      j    = int'(prod >> 31);
      if (j > k) j = k;
      t              = order_model[k];
      order_model[k] = order_model[j];
      order_model[j] = t;
      draws_pending  = draws_pending - 1'b1;
    end else begin
      // advance with wrap, skip the opposite face in cube mode
      last = order_model[pos];
      pos  = (pos + 1) % NUM_IDS;
      if (cube_model && last <= MAX_FACE_ID && order_model[pos] == (last ^ 1))
        pos = (pos + 1) % NUM_IDS;
      cursor_model = OUT_W'(pos);
    end
    res.current_id       = order_model[pos];
    res.cursor           = OUT_W'(pos);
    res.shuffle_complete = (draws_pending == 0);
    return res;
  endfunction

  function automatic logic [RAND_W-1:0] draw_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return WORD_MAX;
      default: return RAND_W'($urandom());
    endcase
  endfunction

  // Send one item, record its expected result, then maybe open a gap
  task automatic send_item(input logic c, input logic [RAND_W-1:0] r);
    req_if.valid       <= 1'b1;
    req_if.cmd         <= c;
    req_if.random_word <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    expected_results.push_back(predict_surface(c, r));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic write_apb(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_CUBE_MODE) cube_model = data[0];
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: own stall pattern plus in-order compare
  logic [9:0] stall_tick = '0;

  function automatic void report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk) begin : rsp_check
    soc_result_t want;
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[9:8])
      2'd0:    rsp_if.ready <= 1'b1;
      2'd1:    rsp_if.ready <= ($urandom_range(0, 2) != 0);
      2'd2:    rsp_if.ready <= (stall_tick[2:0] == 3'd0);
      default: rsp_if.ready <= stall_tick[3];
    endcase
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual id %0d cursor %0d", $time,
                 rsp_if.current_id, rsp_if.cursor);
        mismatch_cnt++;
      end else begin
        want = expected_results.pop_front();
        report_field("current_id", want.current_id, rsp_if.current_id);
        report_field("cursor", want.cursor, rsp_if.cursor);
        report_field("shuffle_complete", want.shuffle_complete, rsp_if.shuffle_complete);
      end
    end
  end

  // Advances straight out of reset walk the identity order
  task automatic check_reset_walk();
    repeat (3) send_item(CMD_ADVANCE, draw_word());
  endtask

  // Extreme random words, a full shuffle, restart, advance mid-shuffle
  task automatic check_draw_extremes();
    repeat (NUM_IDS - 1) send_item(CMD_DRAW, '0);
    send_item(CMD_ADVANCE, WORD_MAX);
    send_item(CMD_DRAW, WORD_MAX);
    send_item(CMD_ADVANCE, '0);
  endtask

  // Identity shuffle by maximal words, then advances that hit opposite faces
  task automatic check_cube_skip();
    wait_idle();
    write_apb(ADDR_CUBE_MODE, 32'h1);
    repeat (NUM_IDS - 2) send_item(CMD_DRAW, WORD_MAX);
    repeat (4) send_item(CMD_ADVANCE, RAND_W'($urandom()));
  endtask

  // Write outside the register map must not touch cube mode
  task automatic check_unmapped_write();
    wait_idle();
    write_apb(ADDR_UNMAPPED, 32'h0);
    repeat (3) send_item(CMD_ADVANCE, draw_word());
  endtask

  // Random phases: mostly full shuffles followed by advance runs, some stray items
  task automatic run_random_mix();
    int            sent;
    logic [PDATA_W-1:0] data;
    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      if (phase % 3 == 2) write_apb(ADDR_UNMAPPED, $urandom());
      data    = $urandom();
      data[0] = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
      write_apb(ADDR_CUBE_MODE, data);
      sent = 0;
      while (sent < 100) begin
        if ($urandom_range(0, 3) != 0) begin
          repeat (NUM_IDS - 1) begin
            send_item(CMD_DRAW, draw_word());
            sent++;
          end
          repeat ($urandom_range(1, 8)) begin
            send_item(CMD_ADVANCE, RAND_W'($urandom()));
            sent++;
          end
        end else begin
          send_item(1'($urandom_range(0, 1)), draw_word());
          sent++;
        end
      end
    end
  endtask

  initial begin
    req_if.valid       <= 1'b0;
    req_if.cmd         <= CMD_DRAW;
    req_if.random_word <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    for (int i = 0; i < NUM_IDS; i++) order_model[i] = OUT_W'(i);
    draws_pending = '0;
    cursor_model  = '0;
    cube_model    = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    check_reset_walk();
    check_draw_extremes();
    check_cube_skip();
    check_unmapped_write();
    run_random_mix();

    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("shuffled_order_cursor_core verification clean");
    end else begin
      $display("shuffled_order_cursor_core verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_400_000;
    $display("shuffled_order_cursor_core verification failed");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/soc_pkg.sv
hw/rtl/soc_if.sv
hw/rtl/soc_apb_regs.sv
hw/rtl/soc_step.sv
hw/rtl/shuffled_order_cursor_core.sv
tb/tb_shuffled_order_cursor_core.sv
